// File: sv/bucket_selection_sorter_defines.svh
// Assertion macros shared by the bucket selection sorter checker.
`ifndef BUCKET_SELECTION_SORTER_DEFINES_SVH
`define BUCKET_SELECTION_SORTER_DEFINES_SVH

// Same-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define BSS_ASSERT_IMPLY(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk_i and quiet while rst_ni is low.
`define BSS_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: sv/bss_pkg.sv
// Types and constants shared by the bucket selection sorter modules.
`timescale 1ns / 1ps
package bss_pkg;

  localparam int VAL_W   = 31;
  localparam int TAG_W   = 3;
  localparam int KEY_W   = TAG_W + VAL_W;
  localparam int BOUND_W = VAL_W + TAG_W;
  localparam int PADDR_W = 3;
  localparam int PDATA_W = 32;

  // Register selected by paddr[2].
  localparam logic REG_BCL2 = 1'b0;
  localparam logic REG_BW   = 1'b1;

  localparam logic [1:0]       BCL2_RESET = 2'd2;
  localparam logic [VAL_W-1:0] BW_RESET   = 31'd536870911;

  typedef struct packed {
    logic load_in;
    logic tag_step;
    logic wr_item;
    logic rd_en;
    logic rd_first;
    logic wr_swap;
    logic emit;
    logic emit_last;
    logic emit_ovf;
  } cmd_t;

  typedef struct packed {
    logic tag_done;
    logic out_busy;
  } sts_t;

endpackage

// File: sv/bss_ram.sv
// Generic simple dual-port RAM with registered read data.
`timescale 1ns / 1ps
module bss_ram #(
  parameter int WIDTH = 34,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// File: sv/bss_datapath.sv
// Datapath: bucket tag search, key store, minimum scan and output register.
`timescale 1ns / 1ps
module bss_datapath #(
  parameter int MAX_ITEMS   = 16,
  parameter int MAX_BUCKETS = 8
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  bss_pkg::cmd_t                cmd_i,
  output bss_pkg::sts_t                sts_o,
  input  logic [$clog2(MAX_ITEMS)-1:0] wr_addr_i,
  input  logic [$clog2(MAX_ITEMS)-1:0] rd_addr_i,
  input  logic [1:0]                   bcl2_i,
  input  logic [bss_pkg::VAL_W-1:0]    bw_i,
  input  logic [bss_pkg::VAL_W-1:0]    in_value_i,
  input  logic                         out_ready_i,
  output logic                         out_valid_o,
  output logic [bss_pkg::VAL_W-1:0]    out_value_o,
  output logic [bss_pkg::TAG_W-1:0]    out_bucket_o,
  output logic                         out_last_o,
  output logic                         out_ovf_o
);
  import bss_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);

  logic [VAL_W-1:0]   v_q;
  logic [TAG_W-1:0]   tag_q;
  logic [BOUND_W-1:0] bound_q;
  logic [3:0]         nb;
  logic [TAG_W-1:0]   nb_m1;

  logic               rd_vld_q, rd_first_q;
  logic [AW-1:0]      rd_idx_q;
  logic [KEY_W-1:0]   rd_data;
  logic [KEY_W-1:0]   best_q, keyi_q;
  logic [AW-1:0]      best_idx_q;

  logic               ram_we;
  logic [AW-1:0]      ram_waddr;
  logic [KEY_W-1:0]   ram_wdata;

  logic               out_valid_q, out_last_q, out_ovf_q;
  logic [VAL_W-1:0]   out_value_q;
  logic [TAG_W-1:0]   out_bucket_q;

  // Number of active buckets, capped by the build-time maximum.
  always_comb begin
    nb = 4'(1) << bcl2_i;
    if (nb > 4'(MAX_BUCKETS)) begin
      nb = 4'(MAX_BUCKETS);
    end
    nb_m1 = TAG_W'(nb - 4'(1));
  end

  // The tag walks upward while the value is at or above the next bucket bound.
  assign sts_o.tag_done = (tag_q == nb_m1) || ({{TAG_W{1'b0}}, v_q} < bound_q);
  assign sts_o.out_busy = out_valid_q && !out_ready_i;

  always_ff @(posedge clk_i) begin
    if (cmd_i.load_in) begin
      v_q     <= in_value_i;
      tag_q   <= '0;
      bound_q <= {{TAG_W{1'b0}}, bw_i};
    end else if (cmd_i.tag_step) begin
      tag_q   <= tag_q + TAG_W'(1);
      bound_q <= bound_q + {{TAG_W{1'b0}}, bw_i};
    end
  end

  assign ram_we    = cmd_i.wr_item || cmd_i.wr_swap;
  assign ram_waddr = cmd_i.wr_swap ? best_idx_q : wr_addr_i;
  assign ram_wdata = cmd_i.wr_swap ? keyi_q : {tag_q, v_q};

  bss_ram #(
    .WIDTH (KEY_W),
    .DEPTH (MAX_ITEMS)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (cmd_i.rd_en),
    .raddr_i (rd_addr_i),
    .rdata_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_vld_q   <= 1'b0;
      rd_first_q <= 1'b0;
    end else begin
      rd_vld_q   <= cmd_i.rd_en;
      rd_first_q <= cmd_i.rd_first;
    end
  end

  // The first beat of a pass is the entry that moves into the slot of the minimum.
  always_ff @(posedge clk_i) begin
    if (cmd_i.rd_en) begin
      rd_idx_q <= rd_addr_i;
    end
    if (rd_vld_q) begin
      if (rd_first_q) begin
        keyi_q     <= rd_data;
        best_q     <= rd_data;
        best_idx_q <= rd_idx_q;
      end else if (rd_data < best_q) begin
        best_q     <= rd_data;
        best_idx_q <= rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.emit) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.emit) begin
      out_value_q  <= best_q[VAL_W-1:0];
      out_bucket_q <= best_q[KEY_W-1:VAL_W];
      out_last_q   <= cmd_i.emit_last;
      out_ovf_q    <= cmd_i.emit_ovf;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_bucket_o = out_bucket_q;
  assign out_last_o   = out_last_q;
  assign out_ovf_o    = out_ovf_q;

endmodule

// File: sv/bss_ctrl.sv
// Controller: item intake, bucket tag search sequencing and selection sort passes.
`timescale 1ns / 1ps
module bss_ctrl #(
  parameter int MAX_ITEMS = 16
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  input  logic                         in_last_i,
  output logic                         in_ready_o,
  input  bss_pkg::sts_t                sts_i,
  output bss_pkg::cmd_t                cmd_o,
  output logic [$clog2(MAX_ITEMS)-1:0] wr_addr_o,
  output logic [$clog2(MAX_ITEMS)-1:0] rd_addr_o
);
  import bss_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);
  localparam int CW = $clog2(MAX_ITEMS + 1);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_TAG,
    ST_STORE,
    ST_SCAN,
    ST_DRAIN,
    ST_EMIT
  } state_e;

  state_e        state_q;
  logic [CW-1:0] cnt_q, i_q, j_q;
  logic          last_q, drop_q;
  logic          full, fin;

  assign full       = (cnt_q == CW'(MAX_ITEMS));
  assign fin        = ((i_q + CW'(1)) == cnt_q);
  assign in_ready_o = (state_q == ST_IDLE);
  assign wr_addr_o  = cnt_q[AW-1:0];
  assign rd_addr_o  = j_q[AW-1:0];

  always_comb begin
    cmd_o = '0;
    unique case (state_q)
      ST_IDLE: begin
        cmd_o.load_in = in_valid_i;
      end
      ST_TAG: begin
        cmd_o.tag_step = !sts_i.tag_done;
      end
      ST_STORE: begin
        cmd_o.wr_item = !full;
      end
      ST_SCAN: begin
        cmd_o.rd_en    = 1'b1;
        cmd_o.rd_first = (j_q == i_q);
      end
      ST_DRAIN: begin
      end
      ST_EMIT: begin
        if (!sts_i.out_busy) begin
          cmd_o.emit      = 1'b1;
          cmd_o.wr_swap   = 1'b1;
          cmd_o.emit_last = fin;
          cmd_o.emit_ovf  = fin && drop_q;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      cnt_q   <= '0;
      i_q     <= '0;
      j_q     <= '0;
      last_q  <= 1'b0;
      drop_q  <= 1'b0;
    end else begin
      unique case (state_q)
        ST_IDLE: begin
          if (in_valid_i) begin
            last_q  <= in_last_i;
            state_q <= ST_TAG;
          end
        end
        ST_TAG: begin
          if (sts_i.tag_done) begin
            state_q <= ST_STORE;
          end
        end
        ST_STORE: begin
          if (!full) begin
            cnt_q <= cnt_q + CW'(1);
          end else begin
            drop_q <= 1'b1;
          end
          if (last_q) begin
            i_q     <= '0;
            j_q     <= '0;
            state_q <= ST_SCAN;
          end else begin
            state_q <= ST_IDLE;
          end
        end
        ST_SCAN: begin
          j_q <= j_q + CW'(1);
          if ((j_q + CW'(1)) == cnt_q) begin
            state_q <= ST_DRAIN;
          end
        end
        ST_DRAIN: begin
          state_q <= ST_EMIT;
        end
        ST_EMIT: begin
          if (!sts_i.out_busy) begin
            if (fin) begin
              cnt_q   <= '0;
              drop_q  <= 1'b0;
              state_q <= ST_IDLE;
            end else begin
              i_q     <= i_q + CW'(1);
              j_q     <= i_q + CW'(1);
              state_q <= ST_SCAN;
            end
          end
        end
        default: begin
          state_q <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

// File: sv/bucket_selection_sorter.sv
// Bucket selection sorter top level: stream ports, register port, controller and datapath.
// An item that is not last goes through accept, 1 to 8 bucket search steps and store.
// A last item then starts n sort passes over the one-read, one-write key RAM; each pass
// scans its entries, drains the read and emits, and may be held by output stalls. Reset
// clears control state and output valid and loads the registers; stale store entries
// are left and never read.
`timescale 1ns / 1ps
module bucket_selection_sorter #(
  parameter int MAX_ITEMS   = 16,
  parameter int MAX_BUCKETS = 8
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [bss_pkg::PADDR_W-1:0]   paddr,
  input  logic [bss_pkg::PDATA_W-1:0]   pwdata,
  output logic [bss_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  // Input stream
  input  logic                          s_axis_tvalid_i,
  output logic                          s_axis_tready_o,
  input  logic [31:0]                   s_axis_tdata_i,   // [30:0] in_value, [31] zero
  input  logic                          s_axis_tlast_i,
  // Output stream
  output logic                          m_axis_tvalid_o,
  input  logic                          m_axis_tready_i,
  output logic [31:0]                   m_axis_tdata_o,   // [30:0] out_value, [31] zero
  output logic [3:0]                    m_axis_tuser_o,   // [2:0] out_bucket, [3] out_overflow
  output logic                          m_axis_tlast_o
);
  import bss_pkg::*;

  localparam int AW = $clog2(MAX_ITEMS);

  logic [1:0]       bcl2_q;
  logic [VAL_W-1:0] bw_q;
  logic             cfg_we;

  cmd_t             cmd;
  sts_t             sts;
  logic [AW-1:0]    wr_addr, rd_addr;
  logic [VAL_W-1:0] out_value;
  logic [TAG_W-1:0] out_bucket;
  logic             out_ovf;

  assign pready = 1'b1;
  assign cfg_we = psel && penable && pwrite;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bcl2_q <= BCL2_RESET;
      bw_q   <= BW_RESET;
    end else if (cfg_we) begin
      unique case (paddr[2])
        REG_BCL2: bcl2_q <= pwdata[1:0];
        REG_BW:   bw_q   <= pwdata[VAL_W-1:0];
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    unique case (paddr[2])
      REG_BCL2: prdata = {{(PDATA_W-2){1'b0}}, bcl2_q};
      REG_BW:   prdata = {{(PDATA_W-VAL_W){1'b0}}, bw_q};
      default:  prdata = '0;
    endcase
  end

  bss_ctrl #(
    .MAX_ITEMS (MAX_ITEMS)
  ) u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (s_axis_tvalid_i),
    .in_last_i  (s_axis_tlast_i),
    .in_ready_o (s_axis_tready_o),
    .sts_i      (sts),
    .cmd_o      (cmd),
    .wr_addr_o  (wr_addr),
    .rd_addr_o  (rd_addr)
  );

  bss_datapath #(
    .MAX_ITEMS   (MAX_ITEMS),
    .MAX_BUCKETS (MAX_BUCKETS)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .wr_addr_i    (wr_addr),
    .rd_addr_i    (rd_addr),
    .bcl2_i       (bcl2_q),
    .bw_i         (bw_q),
    .in_value_i   (s_axis_tdata_i[VAL_W-1:0]),
    .out_ready_i  (m_axis_tready_i),
    .out_valid_o  (m_axis_tvalid_o),
    .out_value_o  (out_value),
    .out_bucket_o (out_bucket),
    .out_last_o   (m_axis_tlast_o),
    .out_ovf_o    (out_ovf)
  );

  assign m_axis_tdata_o = {1'b0, out_value};
  assign m_axis_tuser_o = {out_ovf, out_bucket};

endmodule

// File: sv/bss_checker.sv
// Port-level checker for the bucket selection sorter, bound to the top level.
`timescale 1ns / 1ps
`include "bucket_selection_sorter_defines.svh"
module bss_checker (
  input logic                        clk_i,
  input logic                        rst_ni,
  input logic                        pready,
  input logic                        s_axis_tready_o,
  input logic                        m_axis_tvalid_o,
  input logic                        m_axis_tready_i,
  input logic [31:0]                 m_axis_tdata_o,
  input logic [3:0]                  m_axis_tuser_o,
  input logic                        m_axis_tlast_o
);

  `BSS_ASSERT_IMPLY(a_pready_high, 1'b1, pready, "pready dropped")

  // Overflow is reported only on the final beat of a run.
  `BSS_ASSERT_IMPLY(a_ovf_on_last, m_axis_tvalid_o && m_axis_tuser_o[3], m_axis_tlast_o,
                    "overflow flag on a beat that is not last")

  // While a run is still being emitted no new input beat is taken.
  `BSS_ASSERT_IMPLY(a_no_intake_mid_run, m_axis_tvalid_o && !m_axis_tlast_o, !s_axis_tready_o,
                    "input ready while a sorted run is in progress")

  `BSS_ASSERT_NEXT(a_out_hold, m_axis_tvalid_o && !m_axis_tready_i,
                   m_axis_tvalid_o && $stable(m_axis_tdata_o) && $stable(m_axis_tuser_o)
                   && $stable(m_axis_tlast_o), "stalled output beat changed")

endmodule

bind bucket_selection_sorter bss_checker u_bss_checker (.*);

// File: tb/sv/tb.sv
// Self-checking testbench for the bucket selection sorter stream block.
`timescale 1ns / 1ps
module tb;
  import bss_pkg::*;

  localparam int MAX_ITEMS     = 16;
  localparam int MAX_BUCKETS   = 8;
  localparam int IDLE_SETTLE   = 24;
  localparam int STALL_LIMIT   = 3000;
  localparam int RANDOM_ITEMS  = 70;
  localparam logic [VAL_W-1:0] VALUE_MAX = {VAL_W{1'b1}};

  typedef struct packed {
    logic [VAL_W-1:0] value;
    logic [TAG_W-1:0] bucket;
    logic             last;
    logic             ovf;
  } sorted_beat_t;

  logic                clk_i = 1'b0;
  logic                rst_ni = 1'b0;
  logic                psel = 1'b0;
  logic                penable = 1'b0;
  logic                pwrite = 1'b0;
  logic [PADDR_W-1:0]  paddr = '0;
  logic [PDATA_W-1:0]  pwdata = '0;
  logic [PDATA_W-1:0]  prdata;
  logic                pready;
  logic                s_axis_tvalid_i = 1'b0;
  logic                s_axis_tready_o;
  logic [31:0]         s_axis_tdata_i = '0;   // [30:0] in_value, [31] zero
  logic                s_axis_tlast_i = 1'b0;
  logic                m_axis_tvalid_o;
  logic                m_axis_tready_i = 1'b0;
  logic [31:0]         m_axis_tdata_o;        // [30:0] out_value, [31] zero
  logic [3:0]          m_axis_tuser_o;        // [2:0] out_bucket, [3] out_overflow
  logic                m_axis_tlast_o;

  bucket_selection_sorter #(
    .MAX_ITEMS  (MAX_ITEMS),
    .MAX_BUCKETS(MAX_BUCKETS)
  ) i_dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .s_axis_tvalid_i(s_axis_tvalid_i),
    .s_axis_tready_o(s_axis_tready_o),
    .s_axis_tdata_i (s_axis_tdata_i),
    .s_axis_tlast_i (s_axis_tlast_i),
    .m_axis_tvalid_o(m_axis_tvalid_o),
    .m_axis_tready_i(m_axis_tready_i),
    .m_axis_tdata_o (m_axis_tdata_o),
    .m_axis_tuser_o (m_axis_tuser_o),
    .m_axis_tlast_o (m_axis_tlast_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // Shadow of the registers and of the value store.
  logic [1:0]       cfg_log2 = BCL2_RESET;
  logic [VAL_W-1:0] cfg_width = BW_RESET;
  logic [VAL_W-1:0] held_vals [MAX_ITEMS];
  logic [TAG_W-1:0] held_tags [MAX_ITEMS];
  int               held_count = 0;
  logic             held_dropped = 1'b0;

  sorted_beat_t pending_sorted [$];
  sorted_beat_t got_beat;
  sorted_beat_t want_beat;

  int  error_count = 0;
  int  results_checked = 0;
  int  runs_sent = 0;
  int  overflow_runs = 0;
  int  items_sent = 0;
  int  cfg_writes = 0;
  int  idle_cycles = 0;
  bit  tx_free = 1'b0;
  bit  rx_free = 1'b0;
  int  rx_hold = 0;
  int  rx_roll;

  function automatic logic [TAG_W-1:0] bucket_of(logic [VAL_W-1:0] v);
    int unsigned buckets;
    int unsigned k;
    buckets = 1 << cfg_log2;
    if (buckets > MAX_BUCKETS) buckets = MAX_BUCKETS;
    if (cfg_width == '0) return TAG_W'(buckets - 1);
    k = int'(v / cfg_width);
    if (k > buckets - 1) k = buckets - 1;
    return TAG_W'(k);
  endfunction

  // Store one value; on the last value of a run, queue the whole run in ascending
  // (bucket, value) order with the overflow flag on its final beat.
  task automatic predict_sorted_run(logic [VAL_W-1:0] v, logic last);
    logic [KEY_W-1:0] keys [MAX_ITEMS];
    logic [KEY_W-1:0] swap;
    int               best;
    sorted_beat_t     beat;
    if (held_count < MAX_ITEMS) begin
      held_vals[held_count] = v;
      held_tags[held_count] = bucket_of(v);
      held_count++;
    end else begin
      held_dropped = 1'b1;
    end
    if (!last) return;
    for (int i = 0; i < held_count; i++) keys[i] = {held_tags[i], held_vals[i]};
    for (int i = 0; i + 1 < held_count; i++) begin
      best = i;
      for (int j = i + 1; j < held_count; j++) begin
        if (keys[j] < keys[best]) best = j;
      end
      swap = keys[i];
      keys[i] = keys[best];
      keys[best] = swap;
    end
    for (int i = 0; i < held_count; i++) begin
      beat.value  = keys[i][VAL_W-1:0];
      beat.bucket = keys[i][KEY_W-1:VAL_W];
      beat.last   = (i + 1 == held_count);
      beat.ovf    = (i + 1 == held_count) && held_dropped;
      pending_sorted.push_back(beat);
    end
    runs_sent++;
    if (held_dropped) overflow_runs++;
    held_count = 0;
    held_dropped = 1'b0;
  endtask

  function automatic int next_gap();
    int roll;
    if (tx_free) return 0;
    roll = $urandom_range(0, 99);
    if (roll < 50) return 0;
    if (roll < 92) return $urandom_range(1, 3);
    return $urandom_range(8, 25);
  endfunction

  function automatic logic [VAL_W-1:0] rand_value();
    int     pick;
    longint near;
    pick = $urandom_range(0, 9);
    if (pick < 4) return VAL_W'($urandom());
    if (pick < 6) return VAL_W'($urandom_range(0, 15));
    if (pick == 6) return ($urandom_range(0, 1) != 0) ? VALUE_MAX : '0;
    // Values around the bucket bounds.
    near = longint'(cfg_width) * longint'($urandom_range(1, 8))
           + longint'($urandom_range(0, 2)) - 1;
    if (near < 0) near = 0;
    if (near > longint'(VALUE_MAX)) near = longint'(VALUE_MAX);
    return VAL_W'(near);
  endfunction

  task automatic send_value(logic [VAL_W-1:0] v, logic last);
    int gap;
    gap = next_gap();
    if (gap > 0) begin
      s_axis_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tdata_i  <= {1'b0, v};
    s_axis_tlast_i  <= last;
    do @(posedge clk_i); while (!s_axis_tready_o);
    items_sent++;
    predict_sorted_run(v, last);
  endtask

  // Bring the block to rest: input stream quiet, every result drained, work finished.
  task automatic settle();
    s_axis_tvalid_i <= 1'b0;
    while (pending_sorted.size() != 0) @(posedge clk_i);
    repeat (IDLE_SETTLE) @(posedge clk_i);
  endtask

  task automatic cfg_write(logic reg_sel, logic [PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= PADDR_W'({reg_sel, 2'b00});
    pwdata  <= data;
    @(posedge clk_i);
    penable <= 1'b1;
    @(posedge clk_i);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    if (reg_sel == REG_BCL2) cfg_log2 = data[1:0];
    else cfg_width = data[VAL_W-1:0];
    cfg_writes++;
  endtask

  task automatic configure(logic [1:0] log2, logic [VAL_W-1:0] width);
    cfg_write(REG_BCL2, PDATA_W'(log2));
    cfg_write(REG_BW, PDATA_W'(width));
  endtask

  task automatic test_value_extremes();
    send_value(VALUE_MAX, 1'b1);
    send_value('0, 1'b0);
    send_value(VALUE_MAX, 1'b0);
    send_value(BW_RESET, 1'b0);
    send_value(BW_RESET - 31'd1, 1'b0);
    send_value(BW_RESET + 31'd1, 1'b1);
    settle();
    configure(2'd0, VALUE_MAX);
    send_value(VALUE_MAX, 1'b0);
    send_value('0, 1'b0);
    send_value(31'd1, 1'b1);
    settle();
    configure(2'd3, 31'd1);
    send_value(31'd7, 1'b0);
    send_value('0, 1'b0);
    send_value(31'd2, 1'b0);
    send_value(31'd1, 1'b0);
    send_value(VALUE_MAX, 1'b1);
  endtask

  // With a zero width no bound is ever met, so every value lands in the top bucket.
  task automatic test_zero_width();
    settle();
    configure(2'd3, '0);
    send_value(31'd5, 1'b0);
    send_value('0, 1'b0);
    send_value(VALUE_MAX, 1'b1);
  endtask

  // Values keep the bucket they were given when they arrived.
  task automatic test_mid_run_config();
    settle();
    configure(2'd1, 31'd100);
    send_value(31'd150, 1'b0);
    send_value(31'd20, 1'b0);
    settle();
    configure(2'd3, 31'd10);
    send_value(31'd15, 1'b0);
    send_value(31'd150, 1'b1);
  endtask

  // A full store drops the rest of the run, the last value too, and flags it.
  task automatic test_store_overflow();
    settle();
    configure(2'd2, 31'd1000);
    for (int i = 0; i < MAX_ITEMS; i++) send_value(VAL_W'($urandom_range(0, 5000)), 1'b0);
    send_value(31'd3, 1'b1);
  endtask

  task automatic test_random_runs();
    int run_len;
    int rand_items;
    int run_no;
    rand_items = 0;
    run_no = 0;
    while (rand_items < RANDOM_ITEMS) begin
      if ($urandom_range(0, 2) == 0) begin
        settle();
        case ($urandom_range(0, 6))
          0: configure(2'($urandom_range(0, 3)), '0);
          1: configure(2'($urandom_range(0, 3)), 31'd1);
          2: configure(2'($urandom_range(0, 3)), VAL_W'($urandom_range(2, 20)));
          3: configure(2'($urandom_range(0, 3)), VALUE_MAX);
          4: configure(2'($urandom_range(0, 3)), BW_RESET);
          default: configure(2'($urandom_range(0, 3)), VAL_W'($urandom()));
        endcase
      end
      // One stretch of runs with neither side idling.
      tx_free = (run_no >= 3 && run_no < 6);
      rx_free = tx_free;
      run_len = ($urandom_range(0, 7) == 0) ? $urandom_range(MAX_ITEMS + 1, MAX_ITEMS + 4)
                                            : $urandom_range(1, MAX_ITEMS);
      for (int i = 0; i < run_len; i++) send_value(rand_value(), i == run_len - 1);
      rand_items += run_len;
      run_no++;
    end
    tx_free = 1'b0;
    rx_free = 1'b0;
  endtask

  always @(posedge clk_i) begin
    if (rx_hold > 0) begin
      m_axis_tready_i <= 1'b0;
      rx_hold <= rx_hold - 1;
    end else begin
      m_axis_tready_i <= 1'b1;
      if (!rx_free) begin
        rx_roll = $urandom_range(0, 99);
        if (rx_roll < 20) rx_hold <= $urandom_range(1, 3);
        else if (rx_roll < 23) rx_hold <= $urandom_range(10, 30);
      end
    end
  end

  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i) begin
      got_beat = '{value: m_axis_tdata_o[VAL_W-1:0], bucket: m_axis_tuser_o[TAG_W-1:0],
                   last: m_axis_tlast_o, ovf: m_axis_tuser_o[3]};
      if (pending_sorted.size() == 0) begin
        $display("%0t: unexpected beat: value=%0d bucket=%0d last=%0b ovf=%0b", $time,
                 got_beat.value, got_beat.bucket, got_beat.last, got_beat.ovf);
        error_count++;
      end else begin
        want_beat = pending_sorted.pop_front();
        results_checked++;
        if (got_beat !== want_beat) begin
          $display("%0t: expected value=%0d bucket=%0d last=%0b ovf=%0b,", $time,
                   want_beat.value, want_beat.bucket, want_beat.last, want_beat.ovf,
                   " got value=%0d bucket=%0d last=%0b ovf=%0b",
                   got_beat.value, got_beat.bucket, got_beat.last, got_beat.ovf);
          error_count++;
        end
      end
    end
  end

  // A sort of a full store plus the longest stall stays far below the limit.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid_i && s_axis_tready_o) || (m_axis_tvalid_o && m_axis_tready_i)
        || (psel && penable)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("%0t: no beat accepted for %0d cycles", $time, STALL_LIMIT);
      $display("bucket_selection_sorter: mismatch");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    repeat (6) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_value_extremes();
    test_zero_width();
    test_mid_run_config();
    test_store_overflow();
    test_random_runs();
    settle();
    $display("Sent %0d values in %0d runs (%0d with dropped values), %0d register writes.",
             items_sent, runs_sent, overflow_runs, cfg_writes);
    $display("Checked %0d sorted beats, %0d of them wrong.", results_checked, error_count);
    if (error_count == 0) begin
      $display("bucket_selection_sorter: match");
    end else begin
      $display("bucket_selection_sorter: mismatch");
    end
    $finish;
  end

endmodule
